[hdl/patch_match_propagation_assert.svh]
// assertion macros for the checker file
`ifndef PATCH_MATCH_PROPAGATION_ASSERT_SVH
`define PATCH_MATCH_PROPAGATION_ASSERT_SVH

// a stalled output beat keeps its valid high
`define PMP_HOLD_VALID(label, clk, rst_n, vld, rdy) \
	label: assert property (@(posedge clk) disable iff (!rst_n) \
		(vld && !rdy) |=> vld) else $error("valid dropped while stalled");

// a stalled output beat keeps its payload
`define PMP_HOLD_DATA(label, clk, rst_n, vld, rdy, dat) \
	label: assert property (@(posedge clk) disable iff (!rst_n) \
		(vld && !rdy) |=> $stable(dat)) else $error("payload changed while stalled");

// general implication check
`define PMP_IMPLY(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) \
		(cond) |-> (prop)) else $error("implication failed");

`endif

[hdl/pmp_pkg.sv]
`default_nettype none
package pmp_pkg;
	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int MAX_RADIUS = 7;
	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam int AW = XW + YW;
	localparam int DW = 26;
	localparam int PW = 24;
	localparam int MW = 16;
	localparam int RW = $clog2(MAX_RADIUS + 1);
	localparam int SW = 36;
	localparam logic [DW-1:0] DIST_MAX = '1;

	typedef enum logic [1:0] {
		REQ_WR_A  = 2'd0,
		REQ_WR_B  = 2'd1,
		REQ_SET   = 2'd2,
		REQ_PROP  = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		CFG_WIDTH_A  = 3'd0,
		CFG_HEIGHT_A = 3'd1,
		CFG_WIDTH_B  = 3'd2,
		CFG_HEIGHT_B = 3'd3,
		CFG_RADIUS   = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [XW:0] wa;
		logic [YW:0] ha;
		logic [XW:0] wb;
		logic [YW:0] hb;
		logic [RW-1:0] r;
	} dims_t;

	// distance unit request and response
	typedef struct packed {
		logic          start;
		logic [XW-1:0] bx;
		logic [YW-1:0] by;
		logic [XW-1:0] ax;
		logic [YW-1:0] ay;
	} dreq_t;

	typedef struct packed {
		logic          done;
		logic [DW-1:0] ssd;
	} dres_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_CUR,
		ST_WT_CUR,
		ST_RD_H,
		ST_RD_V,
		ST_CMP_V,
		ST_RD_MATCH,
		ST_DIST_GO,
		ST_DIST_WAIT,
		ST_WRITE,
		ST_OUT
	} state_t;

	function automatic logic [15:0] clamp_dim(input logic [8:0] v, input int hi);
		if (v == 9'd0) return 16'd1;
		if (int'(v) > hi) return 16'(hi);
		return 16'(v);
	endfunction

	function automatic logic [15:0] clamp_coord(input logic signed [15:0] v,
			input logic [15:0] lim);
		if (v < 0) return 16'd0;
		if (v > $signed(lim) - 16'sd1) return lim - 16'd1;
		return 16'(v);
	endfunction
endpackage
`default_nettype wire

[hdl/pmp_dist.sv]
`default_nettype none
module pmp_dist (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire pmp_pkg::dims_t dims,
	input  wire pmp_pkg::dreq_t req,
	output pmp_pkg::dres_t     res,
	output logic [pmp_pkg::AW-1:0] a_addr,
	output logic [pmp_pkg::AW-1:0] b_addr,
	input  wire logic [pmp_pkg::PW-1:0] a_data,
	input  wire logic [pmp_pkg::PW-1:0] b_data
);
	import pmp_pkg::*;

	logic          busy_q, last_q, vld_s1, last_s1, vld_s2, last_s2, done_q;
	logic signed [5:0] dx_q, dy_q;
	logic [XW-1:0] bx_q, ax_q;
	logic [YW-1:0] by_q, ay_q;
	logic [16:0]   sq_s2 [3];
	logic [SW-1:0] sum_q;
	logic signed [5:0] rr;
	logic [15:0]   sax, say, sbx, sby;
	logic signed [8:0] d [3];

	assign rr = 6'(dims.r);
	assign sax = clamp_coord(16'($signed({1'b0, ax_q})) + 16'(dx_q), 16'(dims.wa));
	assign say = clamp_coord(16'($signed({1'b0, ay_q})) + 16'(dy_q), 16'(dims.ha));
	assign sbx = clamp_coord(16'($signed({1'b0, bx_q})) + 16'(dx_q), 16'(dims.wb));
	assign sby = clamp_coord(16'($signed({1'b0, by_q})) + 16'(dy_q), 16'(dims.hb));
	assign a_addr = {say[YW-1:0], sax[XW-1:0]};
	assign b_addr = {sby[YW-1:0], sbx[XW-1:0]};

	always_comb begin
		for (int c = 0; c < 3; c++)
			d[c] = $signed({1'b0, a_data[8*c +: 8]}) - $signed({1'b0, b_data[8*c +: 8]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0; vld_s1 <= 1'b0; vld_s2 <= 1'b0; done_q <= 1'b0;
			last_q <= 1'b0; last_s1 <= 1'b0; last_s2 <= 1'b0;
		end else begin
			done_q <= 1'b0;
			vld_s1 <= busy_q;
			last_s1 <= busy_q && last_q;
			vld_s2 <= vld_s1;
			last_s2 <= last_s1;
			if (req.start) begin
				busy_q <= 1'b1;
				dx_q <= -rr; dy_q <= -rr;
				last_q <= (dims.r == '0);
				bx_q <= req.bx; by_q <= req.by; ax_q <= req.ax; ay_q <= req.ay;
			end else if (busy_q) begin
				if (last_q) busy_q <= 1'b0;
				if (dx_q == rr) begin
					dx_q <= -rr; dy_q <= dy_q + 6'sd1;
				end else begin
					dx_q <= dx_q + 6'sd1;
				end
				last_q <= (dy_q == rr) && (dx_q == rr - 6'sd1);
			end
			if (req.start) sum_q <= '0;
			else if (vld_s2) sum_q <= sum_q + SW'(sq_s2[0]) + SW'(sq_s2[1]) + SW'(sq_s2[2]);
			if (vld_s2 && last_s2) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) sq_s2[c] <= 17'(d[c] * d[c]);
	end

	assign res.done = done_q;
	assign res.ssd = (sum_q > SW'(DIST_MAX)) ? DIST_MAX : sum_q[DW-1:0];
endmodule
`default_nettype wire

[hdl/pmp_store.sv]
`default_nettype none
module pmp_store (
	input  wire logic clk,
	input  wire logic a_we,
	input  wire logic [pmp_pkg::AW-1:0] a_waddr,
	input  wire logic [pmp_pkg::AW-1:0] a_raddr,
	input  wire logic b_we,
	input  wire logic [pmp_pkg::AW-1:0] b_waddr,
	input  wire logic [pmp_pkg::AW-1:0] b_raddr,
	input  wire logic [pmp_pkg::PW-1:0] wdata,
	output logic [pmp_pkg::PW-1:0] a_rdata,
	output logic [pmp_pkg::PW-1:0] b_rdata
);
	import pmp_pkg::*;
	logic [PW-1:0] mem_a [2**AW];
	logic [PW-1:0] mem_b [2**AW];

	always_ff @(posedge clk) begin
		if (a_we) mem_a[a_waddr] <= wdata;
		a_rdata <= mem_a[a_raddr];
	end
	always_ff @(posedge clk) begin
		if (b_we) mem_b[b_waddr] <= wdata;
		b_rdata <= mem_b[b_raddr];
	end
endmodule
`default_nettype wire

[hdl/patch_match_propagation.sv]
// channel | direction | tdata fields (lsb first)                         | tuser
// s_axis  | in        | pos_x pos_y red green blue match_x match_y odd_pass | req_type
// m_axis  | out       | out_x out_y best_x best_y best_distance changed   | none
// cfg     | in        | cfg_we cfg_index cfg_data (9 bits)                | -
// pixel writes go straight to the image stores; set match runs a patch walk, as does
// propagate when a neighbor distance is lower; the walk reads one pixel pair per cycle
// only one item is in flight; s_tready is low until a set or propagate result beat leaves
// arst_n resets control and the config registers; image, match and distance stores hold
// garbage until written
`default_nettype none
module patch_match_propagation (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata, // pos_x pos_y red green blue match_x match_y odd_pass
	input  wire logic [1:0]  s_tuser, // req_type
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata, // out_x out_y best_x best_y best_distance changed
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [8:0]  cfg_data
);
	import pmp_pkg::*;

	// registers
	logic [8:0] wa_q, ha_q, wb_q, hb_q;
	logic [2:0] r_q;
	dims_t dims;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wa_q <= 9'd256; ha_q <= 9'd256; wb_q <= 9'd256; hb_q <= 9'd256; r_q <= 3'd2;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WIDTH_A:  wa_q <= cfg_data;
				CFG_HEIGHT_A: ha_q <= cfg_data;
				CFG_WIDTH_B:  wb_q <= cfg_data;
				CFG_HEIGHT_B: hb_q <= cfg_data;
				CFG_RADIUS:   r_q  <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		logic [15:0] t;
		t = clamp_dim(wa_q, MAX_WIDTH);  dims.wa = t[XW:0];
		t = clamp_dim(ha_q, MAX_HEIGHT); dims.ha = t[YW:0];
		t = clamp_dim(wb_q, MAX_WIDTH);  dims.wb = t[XW:0];
		t = clamp_dim(hb_q, MAX_HEIGHT); dims.hb = t[YW:0];
		dims.r = (int'(r_q) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(r_q);
	end

	// input fields
	logic [XW-1:0] px; logic [YW-1:0] py;
	logic [PW-1:0] pix;
	logic [7:0] in_mx, in_my;
	logic in_odd;
	req_t in_type;
	assign px = s_tdata[7:0];
	assign py = s_tdata[15:8];
	assign pix = s_tdata[39:16];
	assign in_mx = s_tdata[47:40];
	assign in_my = s_tdata[55:48];
	assign in_odd = s_tdata[56];
	assign in_type = req_t'(s_tuser);

	// item registers
	state_t state_q, state_d;
	logic [XW-1:0] bx_q; logic [YW-1:0] by_q;
	logic odd_q, is_set_q, have_q, changed_q;
	logic [MW-1:0] cand_q, match_q;
	logic [DW-1:0] cur_q, best_q;
	logic [AW-1:0] pick_q;
	logic h_ok_q, v_ok_q;

	// match and distance memories, one read port each
	logic [MW-1:0] mem_m [2**AW];
	logic [DW-1:0] mem_d [2**AW];
	logic [AW-1:0] m_raddr, d_raddr, cell_addr;
	logic [MW-1:0] m_rdata;
	logic [DW-1:0] d_rdata;
	logic mem_we;
	logic [MW-1:0] m_wdata;
	logic [DW-1:0] d_wdata;

	assign cell_addr = {by_q, bx_q};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_m[cell_addr] <= m_wdata;
			mem_d[cell_addr] <= d_wdata;
		end
		m_rdata <= mem_m[m_raddr];
		d_rdata <= mem_d[d_raddr];
	end

	// distance unit and pixel stores
	dreq_t dreq; dres_t dres;
	logic [AW-1:0] a_addr, b_addr;
	logic [PW-1:0] a_data, b_data;
	logic acc, wr_a, wr_b;

	assign acc  = s_tvalid && s_tready;
	assign wr_a = acc && in_type == REQ_WR_A && {1'b0, px} < dims.wa && {1'b0, py} < dims.ha;
	assign wr_b = acc && in_type == REQ_WR_B && {1'b0, px} < dims.wb && {1'b0, py} < dims.hb;

	pmp_store u_store (
		.clk(clk), .a_we(wr_a), .a_waddr({py, px}), .a_raddr(a_addr),
		.b_we(wr_b), .b_waddr({py, px}), .b_raddr(b_addr),
		.wdata(pix), .a_rdata(a_data), .b_rdata(b_data)
	);

	pmp_dist u_dist (
		.clk(clk), .arst_n(arst_n), .dims(dims), .req(dreq), .res(dres),
		.a_addr(a_addr), .b_addr(b_addr), .a_data(a_data), .b_data(b_data)
	);

	assign dreq.start = (state_q == ST_DIST_GO);
	assign dreq.bx = bx_q;
	assign dreq.by = by_q;
	assign dreq.ax = cand_q[XW-1:0];
	assign dreq.ay = cand_q[MW-1:XW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// next state and memory addressing
	always_comb begin
		state_d = state_q;
		s_tready = 1'b0;
		m_raddr = cell_addr;
		d_raddr = cell_addr;
		mem_we = 1'b0;
		m_wdata = cand_q;
		d_wdata = dres.ssd;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && (in_type == REQ_SET || in_type == REQ_PROP) &&
						{1'b0, px} < dims.wb && {1'b0, py} < dims.hb)
					state_d = (in_type == REQ_SET) ? ST_DIST_GO : ST_RD_CUR;
			end
			ST_RD_CUR: state_d = ST_WT_CUR;
			ST_WT_CUR: begin
				d_raddr = odd_q ? cell_addr - AW'(1) : cell_addr + AW'(1);
				state_d = ST_RD_H;
			end
			ST_RD_H: begin
				d_raddr = odd_q ? cell_addr - AW'(MAX_WIDTH) : cell_addr + AW'(MAX_WIDTH);
				state_d = ST_RD_V;
			end
			ST_RD_V: state_d = ST_CMP_V;
			ST_CMP_V: begin
				m_raddr = pick_q;
				state_d = have_q ? ST_RD_MATCH : ST_OUT;
			end
			ST_RD_MATCH: state_d = ST_DIST_GO;
			ST_DIST_GO: state_d = ST_DIST_WAIT;
			ST_DIST_WAIT: if (dres.done) state_d = ST_WRITE;
			ST_WRITE: begin
				mem_we = is_set_q || (dres.ssd < cur_q);
				state_d = ST_OUT;
			end
			ST_OUT: if (m_tready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				bx_q <= px; by_q <= py; odd_q <= in_odd;
				is_set_q <= (in_type == REQ_SET);
				cand_q <= {in_my, in_mx};
				match_q <= {in_my, in_mx};
				have_q <= 1'b0; changed_q <= 1'b0;
				h_ok_q <= in_odd ? (px != '0) : ({1'b0, px} + 1'b1 < dims.wb);
				v_ok_q <= in_odd ? (py != '0) : ({1'b0, py} + 1'b1 < dims.hb);
			end
			ST_WT_CUR: begin
				cur_q <= d_rdata; best_q <= d_rdata; match_q <= m_rdata;
			end
			ST_RD_H: begin
				if (h_ok_q && d_rdata < best_q) begin
					best_q <= d_rdata; have_q <= 1'b1;
					pick_q <= odd_q ? cell_addr - AW'(1) : cell_addr + AW'(1);
				end
			end
			ST_RD_V: begin
				if (v_ok_q && d_rdata < best_q) begin
					have_q <= 1'b1;
					pick_q <= odd_q ? cell_addr - AW'(MAX_WIDTH) : cell_addr + AW'(MAX_WIDTH);
				end
			end
			ST_RD_MATCH: cand_q <= m_rdata;
			ST_WRITE: begin
				if (is_set_q || dres.ssd < cur_q) begin
					cur_q <= dres.ssd; match_q <= cand_q; changed_q <= !is_set_q;
				end
			end
			default: ;
		endcase
	end

	// the h-neighbor distance shows in d_rdata during ST_RD_H, the v-neighbor in ST_RD_V
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata = {5'd0, changed_q, cur_q, match_q[MW-1:XW], match_q[XW-1:0], by_q, bx_q};
endmodule
`default_nettype wire

[hdl/pmp_checker.sv]
`default_nettype none
`include "patch_match_propagation_assert.svh"
module pmp_sva (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [63:0] m_tdata
);
	`PMP_HOLD_VALID(a_hold_valid, clk, arst_n, m_tvalid, m_tready)
	`PMP_HOLD_DATA(a_hold_data, clk, arst_n, m_tvalid, m_tready, m_tdata)
	`PMP_IMPLY(a_no_in_while_out, clk, arst_n, m_tvalid, !(s_tvalid && s_tready))
	`PMP_IMPLY(a_pad_zero, clk, arst_n, m_tvalid, m_tdata[63:59] == 5'd0)
endmodule

bind patch_match_propagation pmp_sva u_chk (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire
